// File: sv/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg: shared types and constants of the score command sequencer
// Event codes, request functions, score opcodes, the controller/datapath
// command and status bundles, and the note mapping.
// ----------------------------------------------------------------------------
package scs_pkg;

  // Default sizes
  localparam int SCORE_DEPTH_DEF  = 4096;
  localparam int MAX_COMMANDS_DEF = 62;

  // Field widths fixed by the interface
  localparam int FUNC_W  = 3;
  localparam int LADDR_W = 12;
  localparam int BYTE_W  = 8;
  localparam int FREQ_W  = 16;
  localparam int WAIT_W  = 16;
  localparam int KIND_W  = 3;
  localparam int NOTE_W  = 7;

  // Request functions
  typedef enum logic [FUNC_W-1:0] {
    FN_TICK  = 3'd0,
    FN_LOAD  = 3'd1,
    FN_START = 3'd2,
    FN_STOP  = 3'd3,
    FN_TONE  = 3'd4
  } func_t;

  // Result event kinds
  typedef enum logic [KIND_W-1:0] {
    EV_NONE     = 3'd0,
    EV_NOTE_ON  = 3'd1,
    EV_NOTE_OFF = 3'd2,
    EV_TONE_ON  = 3'd3,
    EV_ALL_OFF  = 3'd4,
    EV_ENDED    = 3'd5,
    EV_ERROR    = 3'd6
  } ev_kind_t;

  // Score opcodes (high nibble of a command byte)
  localparam logic [3:0] OP_NOTE_OFF = 4'h8;
  localparam logic [3:0] OP_NOTE_ON  = 4'h9;
  localparam logic [3:0] OP_RESTART  = 4'hE;
  localparam logic [3:0] OP_STOP     = 4'hF;

  // Note mapping thresholds
  localparam logic [NOTE_W-1:0] NOTE_LOW_LIMIT = 7'd48;
  localparam logic [NOTE_W-1:0] NOTE_LOW_ADD   = 7'd32;
  localparam logic [NOTE_W-1:0] NOTE_HIGH_SUB  = 7'd4;

  // Commands from controller to datapath
  typedef struct packed {
    logic     mem_wr;       // write load byte to score memory
    logic     rd;           // read byte at cursor, advance cursor
    logic     cur_clr;      // cursor to zero
    logic     cur_restore;  // cursor back to the last command address
    logic     tune_set;
    logic     tune_clr;
    logic     tone_set;
    logic     tone_clr;
    logic     wait_load;    // wait counter from tone length
    logic     wait_dec;
    logic     wait_hi;      // wait high byte from read data
    logic     wait_lo;      // wait low byte from read data
    logic     cnt_clr;
    logic     cnt_inc;
    logic     ch_latch;     // capture channel of current command
    logic     freq_latch;
    logic     emit;         // produce an event
    ev_kind_t ev_kind;
    logic     ev_ch;
    logic     flush;        // end of request: release held event as last
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic              wait_zero;
    logic              wait_one;
    logic              tone_active;
    logic              tune_active;
    logic              chan_open;
    logic [BYTE_W-1:0] rdata;
    logic              cnt_full;
    logic              emit_ok;
    logic              ch_ok;
    logic              ch;
  } status_t;

  // Map a score note number to the synth note number
  function automatic logic [NOTE_W-1:0] map_note(input logic [NOTE_W-1:0] n);
    if (n < NOTE_LOW_LIMIT) begin
      return NOTE_W'(n + NOTE_LOW_ADD);
    end else begin
      return NOTE_W'(n - NOTE_HIGH_SUB);
    end
  endfunction

endpackage

// File: sv/scs_ctrl.sv
// ----------------------------------------------------------------------------
// scs_ctrl: request dispatch and score walking controller
// Accepts one request at a time, walks score bytes through the datapath and
// schedules events, stalling whenever the result path is full.
// ----------------------------------------------------------------------------
module scs_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [scs_pkg::FUNC_W-1:0]  in_func,
  input  scs_pkg::status_t            st,
  output scs_pkg::cmd_t               cmd
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_RD      = 11'b00000000010,
    S_CMD     = 11'b00000000100,
    S_WLO     = 11'b00000001000,
    S_NOTE    = 11'b00000010000,
    S_TONEOFF = 11'b00000100000,
    S_STOP0   = 11'b00001000000,
    S_STOP1   = 11'b00010000000,
    S_STOPE   = 11'b00100000000,
    S_TONE    = 11'b01000000000,
    S_FINISH  = 11'b10000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] op;

  assign op       = st.rdata[7:4];
  assign in_ready = (state_r == S_IDLE);

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode state and status into datapath commands
  always_comb begin
    cmd       = '0;
    cmd.ev_kind = scs_pkg::EV_NONE;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_func)
            scs_pkg::FN_TICK: begin
              if (!st.wait_zero) begin
                cmd.wait_dec = 1'b1;
                if (st.wait_one) state_nxt = S_TONEOFF;
              end
            end
            scs_pkg::FN_LOAD: begin
              cmd.mem_wr = 1'b1;
            end
            scs_pkg::FN_START: begin
              cmd.cur_clr  = 1'b1;
              cmd.tune_set = 1'b1;
              cmd.cnt_clr  = 1'b1;
              state_nxt    = S_RD;
            end
            scs_pkg::FN_STOP: begin
              cmd.tune_clr = 1'b1;
              state_nxt    = st.chan_open ? S_STOP0 : S_STOPE;
            end
            scs_pkg::FN_TONE: begin
              if (st.chan_open) begin
                cmd.tone_set   = 1'b1;
                cmd.wait_load  = 1'b1;
                cmd.freq_latch = 1'b1;
                state_nxt      = S_TONE;
              end
            end
            default: ;
          endcase
        end
      end

      // Fetch the next command byte
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CMD;
      end

      // Interpret a command byte
      S_CMD: begin
        cmd.ch_latch = 1'b1;
        if (!st.rdata[7]) begin
          cmd.wait_hi = 1'b1;
          cmd.rd      = 1'b1;
          state_nxt   = S_WLO;
        end else if (op == scs_pkg::OP_STOP) begin
          if (st.emit_ok) begin
            cmd.tune_clr = 1'b1;
            cmd.emit     = 1'b1;
            cmd.ev_kind  = scs_pkg::EV_ENDED;
            state_nxt    = S_FINISH;
          end
        end else if (st.cnt_full) begin
          if (st.emit_ok) begin
            cmd.cur_restore = 1'b1;
            cmd.tune_clr    = 1'b1;
            cmd.emit        = 1'b1;
            cmd.ev_kind     = scs_pkg::EV_ERROR;
            state_nxt       = S_FINISH;
          end
        end else begin
          case (op)
            scs_pkg::OP_NOTE_OFF: begin
              if (st.rdata[3:1] == 3'd0) begin
                if (st.emit_ok) begin
                  cmd.cnt_inc = 1'b1;
                  cmd.emit    = 1'b1;
                  cmd.ev_kind = scs_pkg::EV_NOTE_OFF;
                  cmd.ev_ch   = st.rdata[0];
                  state_nxt   = S_RD;
                end
              end else begin
                cmd.cnt_inc = 1'b1;
                state_nxt   = S_RD;
              end
            end
            scs_pkg::OP_NOTE_ON: begin
              cmd.cnt_inc = 1'b1;
              cmd.rd      = 1'b1;
              state_nxt   = S_NOTE;
            end
            scs_pkg::OP_RESTART: begin
              cmd.cnt_inc = 1'b1;
              cmd.cur_clr = 1'b1;
              state_nxt   = S_RD;
            end
            default: begin
              cmd.cnt_inc = 1'b1;
              state_nxt   = S_RD;
            end
          endcase
        end
      end

      // Low byte of a wait ends the walk
      S_WLO: begin
        cmd.wait_lo = 1'b1;
        state_nxt   = S_FINISH;
      end

      // Note byte of a note on
      S_NOTE: begin
        if (st.chan_open && st.ch_ok && !st.rdata[7]) begin
          if (st.emit_ok) begin
            cmd.emit    = 1'b1;
            cmd.ev_kind = scs_pkg::EV_NOTE_ON;
            cmd.ev_ch   = st.ch;
            state_nxt   = S_RD;
          end
        end else begin
          state_nxt = S_RD;
        end
      end

      // Wait expired: silence the tone if one sounds, then resume the score if one is playing
      S_TONEOFF: begin
        if (st.tone_active) begin
          if (st.emit_ok) begin
            cmd.tone_clr = 1'b1;
            cmd.emit     = 1'b1;
            cmd.ev_kind  = scs_pkg::EV_ALL_OFF;
            cmd.cnt_clr  = 1'b1;
            state_nxt    = st.tune_active ? S_RD : S_FINISH;
          end
        end else begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = st.tune_active ? S_RD : S_FINISH;
        end
      end

      S_STOP0: begin
        if (st.emit_ok) begin
          cmd.emit    = 1'b1;
          cmd.ev_kind = scs_pkg::EV_NOTE_OFF;
          state_nxt   = S_STOP1;
        end
      end

      S_STOP1: begin
        if (st.emit_ok) begin
          cmd.emit    = 1'b1;
          cmd.ev_kind = scs_pkg::EV_NOTE_OFF;
          cmd.ev_ch   = 1'b1;
          state_nxt   = S_STOPE;
        end
      end

      S_STOPE: begin
        if (st.emit_ok) begin
          cmd.emit    = 1'b1;
          cmd.ev_kind = scs_pkg::EV_ENDED;
          state_nxt   = S_FINISH;
        end
      end

      S_TONE: begin
        if (st.emit_ok) begin
          cmd.emit    = 1'b1;
          cmd.ev_kind = scs_pkg::EV_TONE_ON;
          state_nxt   = S_FINISH;
        end
      end

      // Release the held event marked as last
      S_FINISH: begin
        if (st.emit_ok) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: sv/scs_datapath.sv
// ----------------------------------------------------------------------------
// scs_datapath: score memory, cursor, wait counter and event output
// Executes controller commands; holds one event back so that the final event
// of a request can be marked last, and drives the output register.
// ----------------------------------------------------------------------------
module scs_datapath #(
  parameter int SCORE_DEPTH  = scs_pkg::SCORE_DEPTH_DEF,
  parameter int MAX_COMMANDS = scs_pkg::MAX_COMMANDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [scs_pkg::LADDR_W-1:0]  in_load_address,
  input  logic [scs_pkg::BYTE_W-1:0]   in_load_byte,
  input  logic [scs_pkg::FREQ_W-1:0]   in_tone_frequency,
  input  logic [scs_pkg::WAIT_W-1:0]   in_tone_length,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_channels_open,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [scs_pkg::KIND_W-1:0]   out_event_kind,
  output logic                         out_channel,
  output logic [scs_pkg::NOTE_W-1:0]   out_midi_note,
  output logic [scs_pkg::FREQ_W-1:0]   out_frequency,
  output logic                         out_score_playing,
  output logic                         out_last,
  input  scs_pkg::cmd_t                cmd,
  output scs_pkg::status_t             st
);

  localparam int AW = $clog2(SCORE_DEPTH);
  localparam int CW = $clog2(MAX_COMMANDS + 1);

  // Score memory
  logic [scs_pkg::BYTE_W-1:0] mem [SCORE_DEPTH];
  logic [scs_pkg::BYTE_W-1:0] rdata_r;

  logic [AW-1:0]              cursor_r, cursor_nxt, cursor_inc, at_r;
  logic [scs_pkg::WAIT_W-1:0] wait_r, wait_nxt;
  logic                       tune_r, tune_nxt;
  logic                       tone_r, tone_nxt;
  logic                       open_r;
  logic [CW-1:0]              cnt_r;
  logic                       ch_r, ch_ok_r;
  logic [scs_pkg::FREQ_W-1:0] freq_r;
  logic                       load_in_range;

  // Held event
  logic                       pend_valid_r;
  scs_pkg::ev_kind_t          pend_kind_r;
  logic                       pend_ch_r;
  logic [scs_pkg::NOTE_W-1:0] pend_note_r;
  logic [scs_pkg::FREQ_W-1:0] pend_freq_r;
  logic                       pend_play_r;

  logic                       slot_free, push_out;

  assign load_in_range = (32'(in_load_address) < SCORE_DEPTH);
  assign cursor_inc    = (cursor_r == AW'(SCORE_DEPTH - 1)) ? '0 : AW'(cursor_r + 1'b1);

  // Write and read score memory
  always_ff @(posedge clk) begin
    if (cmd.mem_wr && load_in_range) begin
      mem[AW'(in_load_address)] <= in_load_byte;
    end
    if (cmd.rd) begin
      rdata_r <= mem[cursor_r];
    end
  end

  // Next cursor, wait count and flags
  always_comb begin
    cursor_nxt = cursor_r;
    if (cmd.cur_clr) begin
      cursor_nxt = '0;
    end else if (cmd.cur_restore) begin
      cursor_nxt = at_r;
    end else if (cmd.rd) begin
      cursor_nxt = cursor_inc;
    end

    wait_nxt = wait_r;
    if (cmd.wait_load) begin
      wait_nxt = in_tone_length;
    end else if (cmd.wait_dec) begin
      wait_nxt = wait_r - 1'b1;
    end else if (cmd.wait_hi) begin
      wait_nxt = {1'b0, rdata_r[6:0], wait_r[7:0]};
    end else if (cmd.wait_lo) begin
      wait_nxt = {wait_r[15:8], rdata_r};
    end

    tune_nxt = tune_r;
    if (cmd.tune_set) tune_nxt = 1'b1;
    if (cmd.tune_clr) tune_nxt = 1'b0;

    tone_nxt = tone_r;
    if (cmd.tone_set) tone_nxt = 1'b1;
    if (cmd.tone_clr) tone_nxt = 1'b0;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      wait_r   <= '0;
      tune_r   <= 1'b0;
      tone_r   <= 1'b0;
      open_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      cursor_r <= cursor_nxt;
      wait_r   <= wait_nxt;
      tune_r   <= tune_nxt;
      tone_r   <= tone_nxt;
      if (cfg_valid) open_r <= cfg_channels_open;
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= CW'(cnt_r + 1'b1);
      end
    end
  end

  // Command bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.rd) at_r <= cursor_r;
    if (cmd.ch_latch) begin
      ch_r    <= rdata_r[0];
      ch_ok_r <= (rdata_r[3:1] == 3'd0);
    end
    if (cmd.freq_latch) freq_r <= in_tone_frequency;
  end

  // Hold one event, push the previous one out when a new one arrives or the request ends
  assign slot_free = !out_valid || out_ready;
  assign push_out  = (cmd.emit || cmd.flush) && pend_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.emit) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
      if (push_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pend_kind_r <= cmd.ev_kind;
      pend_ch_r   <= cmd.ev_ch;
      pend_note_r <= (cmd.ev_kind == scs_pkg::EV_NOTE_ON) ?
                     scs_pkg::map_note(rdata_r[6:0]) : '0;
      pend_freq_r <= (cmd.ev_kind == scs_pkg::EV_TONE_ON) ? freq_r : '0;
      pend_play_r <= tune_nxt;
    end
    if (push_out) begin
      out_event_kind    <= pend_kind_r;
      out_channel       <= pend_ch_r;
      out_midi_note     <= pend_note_r;
      out_frequency     <= pend_freq_r;
      out_score_playing <= pend_play_r;
      out_last          <= cmd.flush;
    end
  end

  assign cfg_ready = 1'b1;

  // Status to controller
  always_comb begin
    st             = '0;
    st.wait_zero   = (wait_r == '0);
    st.wait_one    = (wait_r == scs_pkg::WAIT_W'(1));
    st.tone_active = tone_r;
    st.tune_active = tune_r;
    st.chan_open   = open_r;
    st.rdata       = rdata_r;
    st.cnt_full    = (cnt_r >= CW'(MAX_COMMANDS));
    st.emit_ok     = !pend_valid_r || slot_free;
    st.ch_ok       = ch_ok_r;
    st.ch          = ch_r;
  end

endmodule

// File: sv/score_command_sequencer.sv
// ----------------------------------------------------------------------------
// score_command_sequencer: two-channel score player with a one-shot tone
// Loads score bytes, walks commands on start and on wait expiry, and reports
// note, tone and status events over a valid/ready result channel.
// ----------------------------------------------------------------------------
// One request is handled at a time. A load, an ignored request or a tick that
// does not expire the wait ends in the accepting cycle. A start walks the score
// through the single read port of the score memory, fetching each command byte
// and the second byte of a note on or wait, then closes the request. An expiring
// tick first silences the tone before the walk. A stop request emits note offs
// if the channels are open, then the end event; a tone request emits its tone
// event. Events wait for a free output slot. The score memory is not cleared
// after reset; read only bytes that have been loaded.
module score_command_sequencer #(
  parameter int SCORE_DEPTH  = scs_pkg::SCORE_DEPTH_DEF,
  parameter int MAX_COMMANDS = scs_pkg::MAX_COMMANDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [scs_pkg::FUNC_W-1:0]   in_func,
  input  logic [scs_pkg::LADDR_W-1:0]  in_load_address,
  input  logic [scs_pkg::BYTE_W-1:0]   in_load_byte,
  input  logic [scs_pkg::FREQ_W-1:0]   in_tone_frequency,
  input  logic [scs_pkg::WAIT_W-1:0]   in_tone_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [scs_pkg::KIND_W-1:0]   out_event_kind,
  output logic                         out_channel,
  output logic [scs_pkg::NOTE_W-1:0]   out_midi_note,
  output logic [scs_pkg::FREQ_W-1:0]   out_frequency,
  output logic                         out_score_playing,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_channels_open
);

  scs_pkg::cmd_t    cmd;
  scs_pkg::status_t st;

  // Controller
  scs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath
  scs_datapath #(
    .SCORE_DEPTH  (SCORE_DEPTH),
    .MAX_COMMANDS (MAX_COMMANDS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_load_address   (in_load_address),
    .in_load_byte      (in_load_byte),
    .in_tone_frequency (in_tone_frequency),
    .in_tone_length    (in_tone_length),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_channels_open (cfg_channels_open),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_kind    (out_event_kind),
    .out_channel       (out_channel),
    .out_midi_note     (out_midi_note),
    .out_frequency     (out_frequency),
    .out_score_playing (out_score_playing),
    .out_last          (out_last),
    .cmd               (cmd),
    .st                (st)
  );

endmodule

// File: sv/scs_checker.sv
// ----------------------------------------------------------------------------
// scs_checker: port-level checks of the score command sequencer
// Watches the result channel for stable stalled requests and legal events.
// ----------------------------------------------------------------------------
module scs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [scs_pkg::KIND_W-1:0]   out_event_kind,
  input logic                         out_channel,
  input logic [scs_pkg::NOTE_W-1:0]   out_midi_note,
  input logic [scs_pkg::FREQ_W-1:0]   out_frequency,
  input logic                         out_score_playing,
  input logic                         out_last
);

  // Hold a stalled result request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_kind) &&
      $stable(out_midi_note) && $stable(out_frequency) && $stable(out_last))
    else $error("stalled result changed");

  // A valid result carries a real event code
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_kind != scs_pkg::EV_NONE &&
      out_event_kind <= scs_pkg::EV_ERROR)
    else $error("illegal event kind");

  // Score has ended after an end or error event
  a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == scs_pkg::EV_ENDED ||
      out_event_kind == scs_pkg::EV_ERROR) |-> !out_score_playing)
    else $error("score still playing after end");

  // Mapped notes stay in the reachable range
  a_note_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == scs_pkg::EV_NOTE_ON |->
      out_midi_note >= 7'd32 && out_midi_note <= 7'd123)
    else $error("note out of mapped range");

  // Only tone events carry a frequency; other non-note events use channel zero
  a_freq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != scs_pkg::EV_TONE_ON |->
      out_frequency == '0 && (out_channel == 1'b0 ||
      out_event_kind == scs_pkg::EV_NOTE_ON ||
      out_event_kind == scs_pkg::EV_NOTE_OFF))
    else $error("stray frequency or channel");

endmodule

bind score_command_sequencer scs_checker u_scs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_event_kind    (out_event_kind),
  .out_channel       (out_channel),
  .out_midi_note     (out_midi_note),
  .out_frequency     (out_frequency),
  .out_score_playing (out_score_playing),
  .out_last          (out_last)
);

// File: bench/score_command_sequencer_tb.sv
// ----------------------------------------------------------------------------
// score_command_sequencer_tb: self-checking bench for the score sequencer
// Drives load, start, stop, tone and tick requests, predicts every note, tone
// and status event from a local model of the player, and checks each result
// in order, field by field, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module score_command_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scs_pkg::*;

  localparam int SCORE_SIZE     = SCORE_DEPTH_DEF;
  localparam int COMMAND_LIMIT  = MAX_COMMANDS_DEF;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int LOW_NOTE_EDGE  = 48;
  localparam int LOW_NOTE_RAISE = 32;
  localparam int HIGH_NOTE_DROP = 4;
  localparam int MAX_NOTE       = 127;
  localparam logic [3:0] OP_UNUSED_LO = 4'hA;
  localparam logic [3:0] OP_UNUSED_HI = 4'hD;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [LADDR_W-1:0] addr;
    logic [BYTE_W-1:0]  data;
    logic [FREQ_W-1:0]  freq;
    logic [WAIT_W-1:0]  length;
  } score_request_t;

  typedef struct packed {
    ev_kind_t          kind;
    logic              chan;
    logic [NOTE_W-1:0] note;
    logic [FREQ_W-1:0] freq;
    logic              playing;
    logic              last;
  } score_event_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [FUNC_W-1:0]   in_func = '0;
  logic [LADDR_W-1:0]  in_load_address = '0;
  logic [BYTE_W-1:0]   in_load_byte = '0;
  logic [FREQ_W-1:0]   in_tone_frequency = '0;
  logic [WAIT_W-1:0]   in_tone_length = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [KIND_W-1:0]   out_event_kind;
  logic                out_channel;
  logic [NOTE_W-1:0]   out_midi_note;
  logic [FREQ_W-1:0]   out_frequency;
  logic                out_score_playing;
  logic                out_last;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_channels_open;

  // Player model state
  bit [BYTE_W-1:0]  score_mem [SCORE_SIZE];
  bit               score_written [SCORE_SIZE];
  bit [LADDR_W-1:0] play_cursor;
  bit [WAIT_W-1:0]  wait_left;
  bit               tune_on;
  bit               tone_on;
  bit               chan_open_m;

  score_event_t   item_events[$];
  score_event_t   pending_events[$];
  score_request_t next_request;
  bit             request_posted = 1'b0;
  bit             idle_on = 1'b1;
  bit             stall_on = 1'b1;
  int             hold_len = 0;
  int             requests_sent = 0;
  int             mismatch_count = 0;

  score_command_sequencer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_load_address   (in_load_address),
    .in_load_byte      (in_load_byte),
    .in_tone_frequency (in_tone_frequency),
    .in_tone_length    (in_tone_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_kind    (out_event_kind),
    .out_channel       (out_channel),
    .out_midi_note     (out_midi_note),
    .out_frequency     (out_frequency),
    .out_score_playing (out_score_playing),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_channels_open (cfg_channels_open)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Player model
  // ---------------------------------------------------------------------------
  function automatic void add_event(ev_kind_t kind, logic chan, logic [NOTE_W-1:0] note,
                                    logic [FREQ_W-1:0] freq);
    score_event_t ev;
    ev.kind    = kind;
    ev.chan    = chan;
    ev.note    = note;
    ev.freq    = freq;
    ev.playing = tune_on;
    ev.last    = 1'b0;
    item_events.push_back(ev);
  endfunction

  // Read the byte under the cursor and advance; flag bytes never loaded
  function automatic logic [BYTE_W-1:0] fetch_score_byte(inout bit ok);
    logic [BYTE_W-1:0] b;
    if (!score_written[play_cursor]) ok = 1'b0;
    b = score_mem[play_cursor];
    play_cursor = play_cursor + 1'b1;
    return b;
  endfunction

  // Walk commands until a wait, a stop or the runaway limit
  function automatic void walk_score(inout bit ok);
    logic [LADDR_W-1:0] cmd_at;
    logic [BYTE_W-1:0]  cmd;
    logic [BYTE_W-1:0]  arg;
    int                 count;
    count = 0;
    forever begin
      cmd_at = play_cursor;
      cmd = fetch_score_byte(ok);
      if (!cmd[7]) begin
        arg = fetch_score_byte(ok);
        wait_left = {1'b0, cmd[6:0], arg};
        break;
      end
      if (cmd[7:4] == OP_STOP) begin
        tune_on = 1'b0;
        add_event(EV_ENDED, 1'b0, '0, '0);
        break;
      end
      if (count >= COMMAND_LIMIT) begin
        play_cursor = cmd_at;
        tune_on = 1'b0;
        add_event(EV_ERROR, 1'b0, '0, '0);
        break;
      end
      count++;
      case (cmd[7:4])
        OP_NOTE_OFF: begin
          if (cmd[3:0] < 2) add_event(EV_NOTE_OFF, cmd[0], '0, '0);
        end
        OP_NOTE_ON: begin
          arg = fetch_score_byte(ok);
          if (chan_open_m && cmd[3:0] < 2 && arg <= MAX_NOTE) begin
            if (arg < LOW_NOTE_EDGE) add_event(EV_NOTE_ON, cmd[0], NOTE_W'(arg + LOW_NOTE_RAISE), '0);
            else add_event(EV_NOTE_ON, cmd[0], NOTE_W'(arg - HIGH_NOTE_DROP), '0);
          end
        end
        OP_RESTART: play_cursor = '0;
        default: ;
      endcase
    end
  endfunction

  // Update the model for one accepted request and queue its events
  function automatic void apply_request(score_request_t r);
    bit ok;
    ok = 1'b1;
    item_events.delete();
    case (r.func)
      FN_TICK: begin
        if (wait_left != 0) begin
          wait_left = wait_left - 1'b1;
          if (wait_left == 0) begin
            if (tone_on) begin
              tone_on = 1'b0;
              add_event(EV_ALL_OFF, 1'b0, '0, '0);
            end
            if (tune_on) walk_score(ok);
          end
        end
      end
      FN_LOAD: begin
        score_mem[r.addr] = r.data;
        score_written[r.addr] = 1'b1;
      end
      FN_START: begin
        play_cursor = '0;
        tune_on = 1'b1;
        walk_score(ok);
      end
      FN_STOP: begin
        tune_on = 1'b0;
        if (chan_open_m) begin
          add_event(EV_NOTE_OFF, 1'b0, '0, '0);
          add_event(EV_NOTE_OFF, 1'b1, '0, '0);
        end
        add_event(EV_ENDED, 1'b0, '0, '0);
      end
      FN_TONE: begin
        if (chan_open_m) begin
          tone_on = 1'b1;
          wait_left = r.length;
          add_event(EV_TONE_ON, 1'b0, '0, r.freq);
        end
      end
      default: ;
    endcase
    if (item_events.size() > 0) item_events[item_events.size() - 1].last = 1'b1;
    foreach (item_events[i]) pending_events.push_back(item_events[i]);
  endfunction

  // True when the request would only read score bytes that were loaded
  function automatic bit request_is_safe(score_request_t r);
    bit [LADDR_W-1:0] keep_cursor;
    bit [WAIT_W-1:0]  keep_wait;
    bit               keep_tune;
    bit               ok;
    keep_cursor = play_cursor;
    keep_wait = wait_left;
    keep_tune = tune_on;
    ok = 1'b1;
    item_events.delete();
    if (r.func == FN_START) begin
      play_cursor = '0;
      tune_on = 1'b1;
      walk_score(ok);
    end else if (r.func == FN_TICK && wait_left == 1 && tune_on) begin
      walk_score(ok);
    end
    play_cursor = keep_cursor;
    wait_left = keep_wait;
    tune_on = keep_tune;
    item_events.delete();
    return ok;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver and result checker
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    in_valid <= request_posted;
    if (request_posted) begin
      in_func           <= next_request.func;
      in_load_address   <= next_request.addr;
      in_load_byte      <= next_request.data;
      in_tone_frequency <= next_request.freq;
      in_tone_length    <= next_request.length;
    end
  end

  // Post one request, hold it until accepted, then predict its events
  task automatic send_request(input score_request_t r);
    if (idle_on && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 15)) @(posedge clk);
    next_request = r;
    request_posted = 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    request_posted = 1'b0;
    if (r.func <= FN_TONE) requests_sent++;
    apply_request(r);
  endtask

  // Replace a request that would read unloaded score bytes by a stop
  task automatic issue_request(input score_request_t r);
    if (!request_is_safe(r)) begin
      r.func = FN_STOP;
    end
    send_request(r);
  endtask

  function automatic score_request_t random_request(logic [FUNC_W-1:0] fn);
    score_request_t r;
    r.func   = fn;
    r.addr   = LADDR_W'($urandom_range(0, SCORE_SIZE - 1));
    r.data   = BYTE_W'($urandom_range(0, 255));
    r.freq   = FREQ_W'($urandom_range(0, 65535));
    r.length = WAIT_W'($urandom_range(0, 65535));
    return r;
  endfunction

  task automatic store_score_byte(input logic [LADDR_W-1:0] a, input logic [BYTE_W-1:0] b);
    score_request_t r;
    r = random_request(FN_LOAD);
    r.addr = a;
    r.data = b;
    issue_request(r);
  endtask

  task automatic send_tone(input logic [FREQ_W-1:0] freq, input logic [WAIT_W-1:0] length);
    score_request_t r;
    r = random_request(FN_TONE);
    r.freq = freq;
    r.length = length;
    issue_request(r);
  endtask

  function automatic void report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endfunction

  // Compare each accepted result with the oldest expected event
  always @(posedge clk) begin : result_check
    score_event_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event kind %0d ch %0d note %0d freq %0d",
                                  out_event_kind, out_channel, out_midi_note, out_frequency));
      end else begin
        want = pending_events.pop_front();
        if (out_event_kind !== want.kind || out_channel !== want.chan ||
            out_midi_note !== want.note || out_frequency !== want.freq ||
            out_score_playing !== want.playing || out_last !== want.last) begin
          report_mismatch($sformatf(
            "expected kind %0d ch %0d note %0d freq %0d playing %0d last %0d, got %0d %0d %0d %0d %0d %0d",
            want.kind, want.chan, want.note, want.freq, want.playing, want.last,
            out_event_kind, out_channel, out_midi_note, out_frequency, out_score_playing,
            out_last));
        end
      end
    end
  end

  // Result side: random stall bursts, plus long hold-offs on request
  always begin : result_sink
    int span;
    @(negedge clk);
    if (hold_len > 0) begin
      out_ready = 1'b0;
      span = hold_len;
      repeat (span - 1) @(negedge clk);
      hold_len = 0;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      out_ready = 1'b0;
      span = $urandom_range(1, 15);
      repeat (span - 1) @(negedge clk);
    end else begin
      out_ready = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Phase control
  // ---------------------------------------------------------------------------
  // Wait until every result is in and the block is back to accepting requests
  task automatic wait_for_drain();
    while (pending_events.size() != 0 || in_valid || !in_ready) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure_channels(input bit open);
    wait_for_drain();
    @(negedge clk);
    cfg_channels_open = open;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    chan_open_m = open;
    @(negedge clk);
    cfg_valid = 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [3:0] pick_channel();
    if ($urandom_range(0, 5) == 0) return 4'($urandom_range(2, 15));
    return 4'($urandom_range(0, 1));
  endfunction

  function automatic logic [WAIT_W-1:0] pick_tone_length();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return WAIT_W'($urandom_range(0, 65535));
      default: return WAIT_W'($urandom_range(1, 6));
    endcase
  endfunction

  // Build a well-formed score at address zero with random content
  task automatic write_random_score();
    logic [BYTE_W-1:0] bytes[$];
    int                n_cmds;
    n_cmds = $urandom_range(2, 10);
    repeat (n_cmds) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          bytes.push_back(($urandom_range(0, 15) == 0) ? BYTE_W'($urandom_range(0, 127)) : 8'd0);
          bytes.push_back(($urandom_range(0, 7) == 0) ? 8'd0 : BYTE_W'($urandom_range(1, 4)));
        end
        2, 3, 4, 9: begin
          bytes.push_back({OP_NOTE_ON, pick_channel()});
          bytes.push_back(($urandom_range(0, 9) == 0) ? BYTE_W'($urandom_range(128, 255)) :
                                                        BYTE_W'($urandom_range(0, 127)));
        end
        5, 6: bytes.push_back({OP_NOTE_OFF, pick_channel()});
        7: bytes.push_back({4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), 4'($urandom)});
        default: bytes.push_back({OP_RESTART, 4'($urandom)});
      endcase
    end
    if ($urandom_range(0, 5) == 0) bytes.push_back({OP_RESTART, 4'($urandom)});
    else bytes.push_back({OP_STOP, 4'($urandom)});
    foreach (bytes[i]) store_score_byte(LADDR_W'(i), bytes[i]);
  endtask

  // Tick through the score, mixing in tones, stops, restarts and noise
  task automatic play_through(input int max_items);
    score_request_t r;
    int             guard;
    guard = 0;
    while ((tune_on || tone_on) && wait_left != 0 && wait_left <= 24 && guard < max_items) begin
      guard++;
      case ($urandom_range(0, 23))
        0: begin
          r = random_request(FN_TONE);
          r.length = pick_tone_length();
        end
        1: r = random_request(FN_STOP);
        2: r = random_request(FUNC_W'($urandom_range(5, 7)));
        3: r = random_request(FN_LOAD);
        4: r = random_request(FN_START);
        default: r = random_request(FN_TICK);
      endcase
      issue_request(r);
    end
    if ($urandom_range(0, 3) == 0) issue_request(random_request(FN_TICK));
  endtask

  task automatic random_phase();
    if ($urandom_range(0, 2) == 0 && score_written[0]) begin
      repeat ($urandom_range(1, 3))
        store_score_byte(LADDR_W'($urandom_range(0, 15)), BYTE_W'($urandom_range(0, 255)));
    end else begin
      write_random_score();
    end
    issue_request(random_request(FN_START));
    play_through(40);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Channels closed after reset: tones ignored, stop gives only the end event
  task automatic test_channels_closed();
    send_tone('1, '1);
    issue_request(random_request(FN_STOP));
    issue_request(random_request(FUNC_W'(5)));
    issue_request(random_request(FUNC_W'(7)));
    issue_request(random_request(FN_TICK));
    configure_channels(1'b1);
  endtask

  // Note mapping edges, dropped notes and channels, skipped opcode, restart
  task automatic test_score_commands();
    logic [BYTE_W-1:0] tune_bytes [18];
    tune_bytes = '{{OP_NOTE_ON, 4'd0}, 8'd0,
                   {OP_NOTE_ON, 4'd1}, 8'd47,
                   {OP_NOTE_ON, 4'd0}, 8'd48,
                   {OP_NOTE_ON, 4'd1}, 8'd127,
                   {OP_NOTE_ON, 4'd0}, 8'd255,
                   {OP_NOTE_ON, 4'd2}, 8'd60,
                   {OP_NOTE_OFF, 4'd0},
                   {OP_NOTE_OFF, 4'd15},
                   {OP_UNUSED_LO, 4'd7},
                   8'd0, 8'd1,
                   {OP_RESTART, 4'd0}};
    foreach (tune_bytes[i]) store_score_byte(LADDR_W'(i), tune_bytes[i]);
    store_score_byte('1, '1);
    issue_request(random_request(FN_START));
    issue_request(random_request(FN_TICK));
    issue_request(random_request(FN_TICK));
    issue_request(random_request(FN_STOP));
  endtask

  // Zero wait stalls; tones take over the wait counter and resume the score
  task automatic test_zero_wait_and_tone();
    store_score_byte(LADDR_W'(0), 8'd0);
    store_score_byte(LADDR_W'(1), 8'd0);
    issue_request(random_request(FN_START));
    issue_request(random_request(FN_TICK));
    send_tone('1, '1);
    send_tone('0, WAIT_W'(1));
    issue_request(random_request(FN_TICK));
    send_tone(FREQ_W'(440), '0);
    issue_request(random_request(FN_TICK));
    issue_request(random_request(FN_STOP));
    store_score_byte(LADDR_W'(0), {OP_NOTE_ON, 4'd0});
    store_score_byte(LADDR_W'(1), 8'd0);
  endtask

  // Hold the result side for a long stretch while requests keep coming
  task automatic test_output_hold();
    wait_for_drain();
    hold_len = HOLD_CYCLES;
    repeat (6) begin
      issue_request(random_request(FN_START));
      issue_request(random_request(FN_STOP));
    end
    wait_for_drain();
  endtask

  // A score that loops without waiting runs into the command limit
  task automatic test_runaway_and_stop();
    store_score_byte(LADDR_W'(0), {OP_NOTE_OFF, 4'd1});
    store_score_byte(LADDR_W'(1), {OP_RESTART, 4'd0});
    issue_request(random_request(FN_START));
    store_score_byte(LADDR_W'(0), {OP_STOP, 4'd0});
    issue_request(random_request(FN_START));
  endtask

  task automatic test_random_play(input int budget);
    int stop_at;
    stop_at = requests_sent + budget;
    while (requests_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0) configure_channels(1'($urandom_range(0, 1)));
      random_phase();
    end
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_steady_stream(input int budget);
    int stop_at;
    wait_for_drain();
    idle_on = 1'b0;
    stall_on = 1'b0;
    configure_channels(1'b1);
    stop_at = requests_sent + budget;
    while (requests_sent < stop_at) random_phase();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_channels_open = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    @(posedge clk);

    test_channels_closed();
    test_score_commands();
    test_zero_wait_and_tone();
    test_output_hold();
    test_runaway_and_stop();
    configure_channels(1'b0);
    test_random_play(120);
    test_steady_stream(30);

    wait_for_drain();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(30_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule

// File: sim.f
sv/scs_pkg.sv
sv/scs_ctrl.sv
sv/scs_datapath.sv
sv/score_command_sequencer.sv
sv/scs_checker.sv
bench/score_command_sequencer_tb.sv
